FILE: rtl/core/imu_angle_packet_decoder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the IMU angle packet decoder
// Checks are sampled on clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef IMU_ANGLE_PACKET_DECODER_DEFINES_SVH
`define IMU_ANGLE_PACKET_DECODER_DEFINES_SVH

// Check a condition at every clock edge out of reset
`define IAPD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("imu_angle_packet_decoder: check failed");

// Check that an antecedent implies a consequent in the same cycle
`define IAPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imu_angle_packet_decoder: implication failed");

// Check that an antecedent implies a consequent in the next cycle
`define IAPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imu_angle_packet_decoder: next-cycle check failed");

`endif

FILE: rtl/core/imuapd_pkg.sv
// ---------------------------------------------------------------------------
// IMU angle packet decoder package
// Framing constants, field widths and the yaw scaling function.
// ---------------------------------------------------------------------------
package imuapd_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned DegW  = 9;
  localparam int unsigned RawW  = 16;
  localparam int unsigned PosW  = 4;
  localparam int unsigned OutTdataW = ((DegW + RawW + 7) / 8) * 8;

  // Header bytes
  localparam logic [ByteW-1:0] HdrFirst  = 8'h55;
  localparam logic [ByteW-1:0] HdrSecond = 8'h53;
  localparam logic [ByteW-1:0] HdrSum    = HdrFirst + HdrSecond;

  // Byte positions inside an 11-byte packet
  localparam logic [PosW-1:0] PosHunt   = 4'd0;
  localparam logic [PosW-1:0] PosSecond = 4'd1;
  localparam logic [PosW-1:0] PosBody   = 4'd2;
  localparam logic [PosW-1:0] PosYawLo  = 4'd6;
  localparam logic [PosW-1:0] PosYawHi  = 4'd7;
  localparam logic [PosW-1:0] PosCheck  = 4'd10;

  // Degrees per full-scale word, and the scale shift (32768 = 2**15)
  localparam logic [7:0] DegScale = 8'd180;
  localparam int unsigned ScaleShift = 15;

  // raw * 180 / 32768, truncated toward zero
  function automatic logic signed [DegW-1:0] yaw_to_degrees(logic signed [RawW-1:0] raw);
    logic [RawW-1:0]       mag;
    logic [RawW+7:0]       prod;
    logic [7:0]            quo;
    logic [DegW-1:0]       pos_deg;
    mag     = raw[RawW-1] ? (~raw + 1'b1) : raw;
    prod    = {8'b0, mag} * {{RawW{1'b0}}, DegScale};
    quo     = prod[ScaleShift+7:ScaleShift];
    pos_deg = {1'b0, quo};
    return raw[RawW-1] ? $signed(~pos_deg + 1'b1) : $signed(pos_deg);
  endfunction

endpackage

FILE: rtl/core/imu_angle_packet_decoder.sv
// ---------------------------------------------------------------------------
// IMU angle packet decoder
// Frames 11-byte angle packets from a serial byte stream and emits yaw.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one received serial byte per word. The decoder
//   hunts for the header 0x55 0x53, collects nine more bytes and checks the
//   eleventh against the 8-bit sum of the first ten. On a match the master
//   channel carries one word: yaw in whole degrees and the raw signed yaw.
//   The result word is registered and valid in the cycle after the checksum
//   byte is accepted. Throughput: one byte per cycle while the slave side is
//   ready; a packet yields at most one result every 11 bytes.
//   The slave side is ready whenever the result register can take a new
//   word: it only drops while the decoder waits for the checksum byte, an
//   earlier result still waits and the master side is stalled.
//   Reset clears the byte position, running sum and result valid; the
//   decoder starts hunting for a header.
// ---------------------------------------------------------------------------
`include "imu_angle_packet_decoder_defines.svh"

module imu_angle_packet_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [imuapd_pkg::OutTdataW-1:0] m_axis_tdata  // [8:0] yaw_degrees,
                                                         // [24:9] yaw_raw, rest 0
);

  logic [imuapd_pkg::PosW-1:0]  pos_q, pos_d;
  logic [imuapd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [imuapd_pkg::ByteW-1:0] yaw_lo_q, yaw_hi_q;
  logic                         out_valid_q, out_valid_d;
  logic signed [imuapd_pkg::DegW-1:0] deg_q;
  logic signed [imuapd_pkg::RawW-1:0] raw_q;

  logic                         in_acc;
  logic                         out_acc;
  logic                         result_hit;
  logic [imuapd_pkg::ByteW-1:0] rx_byte;
  logic signed [imuapd_pkg::RawW-1:0] raw_word;

  assign rx_byte = s_axis_tdata;
  assign out_acc = out_valid_q && m_axis_tready;

  // Stall only a checksum byte that would overwrite a pending result
  assign s_axis_tready = !((pos_q == imuapd_pkg::PosCheck) && out_valid_q && !m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign raw_word   = $signed({yaw_hi_q, yaw_lo_q});
  assign result_hit = in_acc && (pos_q == imuapd_pkg::PosCheck) && (rx_byte == sum_q);

  // Advance byte position and running sum
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (in_acc) begin
      case (pos_q)
        imuapd_pkg::PosHunt: begin
          if (rx_byte == imuapd_pkg::HdrFirst) begin
            pos_d = imuapd_pkg::PosSecond;
            sum_d = imuapd_pkg::HdrFirst;
          end
        end
        imuapd_pkg::PosSecond: begin
          if (rx_byte == imuapd_pkg::HdrSecond) begin
            pos_d = imuapd_pkg::PosBody;
            sum_d = imuapd_pkg::HdrSum;
          end else if (rx_byte == imuapd_pkg::HdrFirst) begin
            pos_d = imuapd_pkg::PosSecond;
            sum_d = imuapd_pkg::HdrFirst;
          end else begin
            pos_d = imuapd_pkg::PosHunt;
          end
        end
        imuapd_pkg::PosCheck: begin
          pos_d = imuapd_pkg::PosHunt;
        end
        default: begin
          if (pos_q > imuapd_pkg::PosCheck) begin
            // Out-of-range position behaves as hunting
            if (rx_byte == imuapd_pkg::HdrFirst) begin
              pos_d = imuapd_pkg::PosSecond;
              sum_d = imuapd_pkg::HdrFirst;
            end else begin
              pos_d = imuapd_pkg::PosHunt;
            end
          end else begin
            pos_d = pos_q + 1'b1;
            sum_d = sum_q + rx_byte;
          end
        end
      endcase
    end
  end

  // Hold or release the result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_hit) begin
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= imuapd_pkg::PosHunt;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture yaw bytes
  always_ff @(posedge clk_i) begin
    if (in_acc && (pos_q == imuapd_pkg::PosYawLo)) begin
      yaw_lo_q <= rx_byte;
    end
    if (in_acc && (pos_q == imuapd_pkg::PosYawHi)) begin
      yaw_hi_q <= rx_byte;
    end
  end

  // Load the result word on a checksum match
  always_ff @(posedge clk_i) begin
    if (result_hit) begin
      raw_q <= raw_word;
      deg_q <= imuapd_pkg::yaw_to_degrees(raw_word);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(imuapd_pkg::OutTdataW - imuapd_pkg::DegW - imuapd_pkg::RawW){1'b0}},
                          raw_q, deg_q};

  // Checks
  `IAPD_ASSERT(a_pos_range, pos_q <= imuapd_pkg::PosCheck)
  `IAPD_ASSERT_IMPL(a_stall_cause, !s_axis_tready,
                    out_valid_q && (pos_q == imuapd_pkg::PosCheck))
  `IAPD_ASSERT_NEXT(a_check_rearm, in_acc && (pos_q == imuapd_pkg::PosCheck),
                    pos_q == imuapd_pkg::PosHunt)
  `IAPD_ASSERT_IMPL(a_result_source, $rose(out_valid_q),
                    $past(in_acc && (pos_q == imuapd_pkg::PosCheck)))

endmodule

FILE: tb/tb_imu_angle_packet_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the IMU angle packet decoder
// Streams serial bytes into the decoder: header corner cases, a corrupted
// checksum, then a long mix of well-formed and bad-checksum packets, broken
// headers and line noise. A local decoder model predicts every yaw word.
// Each result word is checked field by field against the oldest prediction.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_imu_angle_packet_decoder;

  localparam int PktLen      = 11;
  localparam int TargetBytes = 850;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic signed [imuapd_pkg::DegW-1:0] deg;
    logic signed [imuapd_pkg::RawW-1:0] raw;
  } yaw_word_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [imuapd_pkg::ByteW-1:0]     s_axis_tdata = '0;  // [7:0] rx_byte
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [imuapd_pkg::OutTdataW-1:0] m_axis_tdata;       // [8:0] yaw_degrees, [24:9] yaw_raw

  // Local copy of the decoder state
  logic [imuapd_pkg::PosW-1:0]  frame_pos = imuapd_pkg::PosHunt;
  logic [imuapd_pkg::ByteW-1:0] frame_sum = '0;
  logic [imuapd_pkg::ByteW-1:0] yaw_lo_q  = '0;
  logic [imuapd_pkg::ByteW-1:0] yaw_hi_q  = '0;

  yaw_word_t yaw_expected[$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  int        burst_left = 0;
  int        stall_mode = 0;
  int        stall_tick = 0;

  imu_angle_packet_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // raw * 180 / 32768, truncated toward zero
  function automatic logic signed [imuapd_pkg::DegW-1:0] yaw_in_degrees(
      input logic signed [imuapd_pkg::RawW-1:0] raw);
    int r;
    int m;
    int q;
    int d;
    r = int'(raw);
    m = (r < 0) ? -r : r;
    q = (m * 180) >>> 15;
    d = (r < 0) ? -q : q;
    return $signed(d[imuapd_pkg::DegW-1:0]);
  endfunction

  // Advance the local decoder by one accepted byte
  task automatic decode_byte(input logic [imuapd_pkg::ByteW-1:0] b);
    logic [imuapd_pkg::PosW-1:0] pos;
    yaw_word_t                   w;
    pos = (frame_pos > imuapd_pkg::PosCheck) ? imuapd_pkg::PosHunt : frame_pos;
    if (pos == imuapd_pkg::PosHunt) begin
      if (b == imuapd_pkg::HdrFirst) begin
        frame_sum = imuapd_pkg::HdrFirst;
        frame_pos = imuapd_pkg::PosSecond;
      end else begin
        frame_pos = imuapd_pkg::PosHunt;
      end
    end else if (pos == imuapd_pkg::PosSecond) begin
      if (b == imuapd_pkg::HdrSecond) begin
        frame_sum = imuapd_pkg::HdrSum;
        frame_pos = imuapd_pkg::PosBody;
      end else if (b == imuapd_pkg::HdrFirst) begin
        frame_sum = imuapd_pkg::HdrFirst;
        frame_pos = imuapd_pkg::PosSecond;
      end else begin
        frame_pos = imuapd_pkg::PosHunt;
      end
    end else if (pos < imuapd_pkg::PosCheck) begin
      if (pos == imuapd_pkg::PosYawLo) yaw_lo_q = b;
      if (pos == imuapd_pkg::PosYawHi) yaw_hi_q = b;
      frame_sum = frame_sum + b;
      frame_pos = pos + 1'b1;
    end else begin
      // Checksum byte: emit only on a match
      frame_pos = imuapd_pkg::PosHunt;
      if (b == frame_sum) begin
        w.raw = {yaw_hi_q, yaw_lo_q};
        w.deg = yaw_in_degrees(w.raw);
        yaw_expected.push_back(w);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  task automatic check_yaw_word(input logic [imuapd_pkg::OutTdataW-1:0] d);
    yaw_word_t want;
    if (yaw_expected.size() == 0) begin
      report_mismatch("unexpected result word", d, 0);
      return;
    end
    want = yaw_expected.pop_front();
    if (d[imuapd_pkg::DegW-1:0] !== want.deg)
      report_mismatch("yaw_degrees", int'($signed(d[imuapd_pkg::DegW-1:0])),
                      int'(want.deg));
    if (d[imuapd_pkg::DegW+imuapd_pkg::RawW-1:imuapd_pkg::DegW] !== want.raw)
      report_mismatch("yaw_raw",
                      int'($signed(d[imuapd_pkg::DegW+imuapd_pkg::RawW-1:imuapd_pkg::DegW])),
                      int'(want.raw));
    if (d[imuapd_pkg::OutTdataW-1:imuapd_pkg::DegW+imuapd_pkg::RawW] !== '0)
      report_mismatch("tdata padding",
                      int'(d[imuapd_pkg::OutTdataW-1:imuapd_pkg::DegW+imuapd_pkg::RawW]), 0);
  endtask

  // Sample both channels mid-cycle; a handshake seen here completes at the next edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_yaw_word(m_axis_tdata);
    end
  end

  // Receiver stall pattern: switch between free-running, random, sparse and periodic
  always @(posedge clk_i) begin
    if (stall_tick == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_tick <= $urandom_range(16, 96);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 5) == 0);
      end
      default: begin
        m_axis_tready <= stall_tick[2];
      end
    endcase
  end

  // Send one byte, with bursts of random length and random gaps between them
  task automatic send_byte(input logic [imuapd_pkg::ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send a full packet; extra_hdr repeats the first header byte, bad_sum corrupts the checksum
  task automatic send_packet(input logic [imuapd_pkg::RawW-1:0] yaw, input int extra_hdr,
                             input bit bad_sum);
    logic [imuapd_pkg::ByteW-1:0] pkt[PktLen];
    logic [imuapd_pkg::ByteW-1:0] sum;
    sum = '0;
    for (int i = 0; i < PktLen - 1; i++) pkt[i] = 8'($urandom_range(0, 255));
    pkt[0] = imuapd_pkg::HdrFirst;
    pkt[1] = imuapd_pkg::HdrSecond;
    pkt[imuapd_pkg::PosYawLo] = yaw[7:0];
    pkt[imuapd_pkg::PosYawHi] = yaw[15:8];
    for (int i = 0; i < PktLen - 1; i++) sum = sum + pkt[i];
    pkt[PktLen-1] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
    send_byte(pkt[0]);
    repeat (extra_hdr) send_byte(imuapd_pkg::HdrFirst);
    for (int i = 1; i < PktLen; i++) send_byte(pkt[i]);
  endtask

  // A run of first header bytes keeps the decoder waiting for the second
  task automatic test_repeated_header();
    send_packet(16'h7FFF, 1, 1'b0);
  endtask

  // A wrong second byte drops back to hunting; a following 0x53 is no start
  task automatic test_bad_second_header();
    send_byte(imuapd_pkg::HdrFirst);
    send_byte(8'h12);
    send_byte(imuapd_pkg::HdrSecond);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // A corrupted checksum yields no word
  task automatic test_bad_checksum();
    send_packet(16'h8000, 0, 1'b1);
  endtask

  // Mostly valid packets with random content, mixed with noise and broken frames
  task automatic test_random_stream();
    logic [imuapd_pkg::RawW-1:0] corners[10] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                                                 16'h8001, 16'hFFFF, 16'h00B6, 16'h4000,
                                                 16'hC000, 16'h00B7};
    int corner_idx;
    int pick;
    corner_idx = 0;
    while (bytes_sent < TargetBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (corner_idx < $size(corners)) begin
          send_packet(corners[corner_idx], 0, 1'b0);
          corner_idx++;
        end else begin
          send_packet(16'($urandom_range(0, 16'hFFFF)),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
        end
      end else if (pick < 80) begin
        send_packet(16'($urandom_range(0, 16'hFFFF)), 0, 1'b1);
      end else if (pick < 88) begin
        // Broken header or cut-short frame
        send_byte(imuapd_pkg::HdrFirst);
        if ($urandom_range(0, 1)) send_byte(imuapd_pkg::HdrSecond);
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_repeated_header();
    test_bad_second_header();
    test_bad_checksum();
    test_random_stream();

    // Drain: wait for every expected word, then watch for stray words
    s_axis_tvalid <= 1'b0;
    while (yaw_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard limit on the run time
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: imu_angle_packet_decoder.f
+incdir+rtl/core
rtl/core/imuapd_pkg.sv
rtl/core/imu_angle_packet_decoder.sv
tb/tb_imu_angle_packet_decoder.sv
